>>> rtl/mrfq_pkg.sv
// ----------------------------------------------------------------------------
// mrfq_pkg: shared types and codes of the multi-reader frame queue
// Holds the channel payload structs, the operation, status and command codes,
// and the status bundle that the execution engine hands to the front end.
// ----------------------------------------------------------------------------
package mrfq_pkg;

   // field widths of the channels
   localparam int HANDLE_W    = 16;
   localparam int OPERATION_W = 3;
   localparam int READER_W    = 3;
   localparam int STATUS_W    = 2;
   localparam int OCCUPANCY_W = 4;
   localparam int SLOTS_W     = 3;

   // reader slots that the engine holds; a larger slot count saturates to this
   localparam int MAX_READERS = 4;

   // operation codes on the request channel
   localparam logic [OPERATION_W-1:0] OP_ENQUEUE = 3'd0;
   localparam logic [OPERATION_W-1:0] OP_DEQUEUE = 3'd1;
   localparam logic [OPERATION_W-1:0] OP_READ    = 3'd2;
   localparam logic [OPERATION_W-1:0] OP_OPEN    = 3'd3;
   localparam logic [OPERATION_W-1:0] OP_CLOSE   = 3'd4;
   localparam logic [OPERATION_W-1:0] OP_FIND    = 3'd5;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REFUSED = 2'd2;

   // command kinds after classification
   localparam int KIND_W = 3;
   localparam logic [KIND_W-1:0] KIND_ENQUEUE = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DEQUEUE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_READ    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_OPEN    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLOSE   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_FIND    = 3'd5;
   localparam logic [KIND_W-1:0] KIND_REFUSE  = 3'd6;

   // command queue between front end and engine
   localparam int CMD_QUEUE_DEPTH = 2;
   localparam int CMD_QUEUE_AW    = $clog2(CMD_QUEUE_DEPTH);

   typedef struct packed {
      logic [OPERATION_W-1:0] operation;
      logic [HANDLE_W-1:0]    handle;
      logic [READER_W-1:0]    reader_id;
      logic                   discard;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [HANDLE_W-1:0]    handle_out;
      logic [READER_W-1:0]    reader_out;
      logic [HANDLE_W-1:0]    released_handle;
      logic                   found;
      logic [OCCUPANCY_W-1:0] occupancy;
   } rsp_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [HANDLE_W-1:0] handle;
      logic [READER_W-1:0] reader_idx;  // zero-based, checked in range
      logic                discard;
   } cmd_type;

   typedef struct packed {
      logic               idle;
      logic               broadcast;
      logic [SLOTS_W-1:0] readers;       // effective reader slot count
   } back_status_type;

endpackage

>>> rtl/mrfq_front.sv
// ----------------------------------------------------------------------------
// mrfq_front: request classification
// Checks each request against the current mode and turns it into a command
// for the engine; requests that can only be refused are marked as such.
// ----------------------------------------------------------------------------
module mrfq_front (
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  mrfq_pkg::req_type        req_data,
   input  mrfq_pkg::back_status_type back_status,
   output logic                     push_valid,
   input  logic                     push_ready,
   output mrfq_pkg::cmd_type        push_data
);
   import mrfq_pkg::*;

   logic reader_ok;
   logic handle_null;

   // reader id must name a slot within the effective count
   assign reader_ok   = (req_data.reader_id != '0) &&
                        (req_data.reader_id <= back_status.readers);
   assign handle_null = (req_data.handle == '0);

   // classify the request
   always_comb begin
      push_data.handle     = req_data.handle;
      push_data.discard    = req_data.discard;
      push_data.reader_idx = req_data.reader_id - 3'd1;
      unique case (req_data.operation)
         OP_ENQUEUE: push_data.kind = handle_null ? KIND_REFUSE : KIND_ENQUEUE;
         OP_DEQUEUE: push_data.kind = KIND_DEQUEUE;
         OP_READ: begin
            push_data.kind = (back_status.broadcast && reader_ok) ? KIND_READ : KIND_REFUSE;
         end
         OP_OPEN:    push_data.kind = back_status.broadcast ? KIND_OPEN : KIND_REFUSE;
         OP_CLOSE: begin
            push_data.kind = (back_status.broadcast && reader_ok) ? KIND_CLOSE : KIND_REFUSE;
         end
         OP_FIND:    push_data.kind = handle_null ? KIND_REFUSE : KIND_FIND;
         default:    push_data.kind = KIND_REFUSE;
      endcase
   end

   // request transfer goes straight into the command queue
   assign push_valid = req_valid & ~reset;
   assign req_ready  = push_ready & ~reset;

endmodule

>>> rtl/mrfq_cmd_fifo.sv
// ----------------------------------------------------------------------------
// mrfq_cmd_fifo: command queue
// Short queue of classified commands that lets the front end keep taking
// requests while the engine works on an earlier one.
// ----------------------------------------------------------------------------
module mrfq_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  mrfq_pkg::cmd_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output mrfq_pkg::cmd_type pop_data
);
   import mrfq_pkg::*;

   localparam int CW = CMD_QUEUE_AW + 1;

   cmd_type                 entry_ff [CMD_QUEUE_DEPTH];
   logic [CMD_QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]           count_ff,  count_in;
   logic                    push, pop;

   assign push_ready = (count_ff != CW'(CMD_QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // pointer and count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      priority if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/mrfq_back.sv
// ----------------------------------------------------------------------------
// mrfq_back: queue execution engine
// Owns the slot memory, head and tail, reader positions and the mode
// register; runs one command at a time and loads the response register.
// ----------------------------------------------------------------------------
module mrfq_back #(
   parameter int CAPACITY    = 15
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                cmd_valid,
   output logic                                cmd_pop,
   input  mrfq_pkg::cmd_type                   cmd_data,
   input  logic                                csr_write,
   input  logic [mrfq_pkg::SLOTS_W-1:0]        csr_data,
   output mrfq_pkg::back_status_type           back_status,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output mrfq_pkg::rsp_type                   rsp_data
);
   import mrfq_pkg::*;

   localparam int RING = CAPACITY + 1;
   localparam int PW   = $clog2(RING);
   localparam int DW   = PW + 1;
   localparam int IW   = $clog2(MAX_READERS);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EXEC   = 3'd1;
   localparam logic [2:0] ST_TAKE   = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_HEADMV = 3'd4;
   localparam logic [2:0] ST_REL    = 3'd5;
   localparam logic [2:0] ST_FRD    = 3'd6;
   localparam logic [2:0] ST_FCMP   = 3'd7;

   // ring helpers
   function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
      logic [PW-1:0] r;
      if (int'(p) == RING - 1) r = '0;
      else r = p + 1'b1;
      return r;
   endfunction

   function automatic logic [DW-1:0] ring_dist(input logic [PW-1:0] from,
                                               input logic [PW-1:0] to);
      logic [DW-1:0] f, t, r;
      f = {1'b0, from};
      t = {1'b0, to};
      if (t >= f) r = t - f;
      else r = t + DW'(RING) - f;
      return r;
   endfunction

   function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] p,
                                              input logic [PW-1:0] d);
      logic [DW-1:0] s;
      s = {1'b0, p} + {1'b0, d};
      if (s >= DW'(RING)) s = s - DW'(RING);
      return s[PW-1:0];
   endfunction

   // state
   logic [2:0]             state_ff, state_in;
   logic [PW-1:0]          head_ff, head_in;
   logic [PW-1:0]          tail_ff, tail_in;
   logic [PW-1:0]          pos_ff [MAX_READERS];
   logic [PW-1:0]          pos_in [MAX_READERS];
   logic [PW-1:0]          pos_adv [MAX_READERS];
   logic [MAX_READERS-1:0] open_ff, open_in;
   logic [SLOTS_W-1:0]     slots_ff, slots_in;
   cmd_type                cmd_ff, cmd_in;
   rsp_type                res_ff, res_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0]          scan_ff, scan_in;
   logic [DW-1:0]          best_ff, best_in;
   logic [PW-1:0]          ptr_ff, ptr_in;
   logic [DW-1:0]          seg_end_ff, seg_end_in;
   logic                   more_ff, more_in;

   // slot memory
   logic [HANDLE_W-1:0]    slot_mem [RING];
   logic [HANDLE_W-1:0]    rd_data_ff;
   logic                   mem_we, mem_re;
   logic [PW-1:0]          mem_waddr, mem_raddr;
   logic [HANDLE_W-1:0]    mem_wdata;

   // scratch
   logic [SLOTS_W-1:0]     eff_n;
   logic                   broadcast;
   logic                   out_free;
   logic                   finish;
   logic [IW-1:0]          ridx;
   logic                   full;
   logic                   free_hit;
   logic [IW-1:0]          free_idx;
   logic [READER_W-1:0]    free_num;
   logic [DW-1:0]          d_scan;
   logic [DW-1:0]          ptr_inc;
   logic [DW+OCCUPANCY_W-1:0] occ_wide;

   // effective reader count with saturation
   always_comb begin
      priority if (slots_ff == '0) begin
         eff_n = SLOTS_W'(1);
      end else if (int'(slots_ff) > MAX_READERS) begin
         eff_n = SLOTS_W'(MAX_READERS);
      end else begin
         eff_n = slots_ff;
      end
   end
   assign broadcast = (eff_n > SLOTS_W'(1));

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign cmd_pop  = (state_ff == ST_IDLE) && cmd_valid && out_free;

   assign back_status.idle      = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign back_status.broadcast = broadcast;
   assign back_status.readers   = eff_n;

   // readers that sit on the head move along with it
   always_comb begin
      for (int i = 0; i < MAX_READERS; i++) begin
         if (open_ff[i] && (i < int'(eff_n)) && (pos_ff[i] == head_ff)) begin
            pos_adv[i] = ring_next(head_ff);
         end else begin
            pos_adv[i] = pos_ff[i];
         end
      end
   end

   // first closed reader slot
   always_comb begin
      free_hit = 1'b0;
      free_idx = '0;
      free_num = '0;
      for (int i = 0; i < MAX_READERS; i++) begin
         if (!free_hit && (i < int'(eff_n)) && !open_ff[i]) begin
            free_hit = 1'b1;
            free_idx = IW'(i);
            free_num = READER_W'(i + 1);
         end
      end
   end

   assign ridx    = IW'(cmd_ff.reader_idx);
   assign full    = (ring_next(tail_ff) == head_ff);
   assign d_scan  = ring_dist(head_ff, pos_ff[scan_ff]);
   assign ptr_inc = {1'b0, ptr_ff} + 1'b1;

   // command sequencer
   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      pos_in     = pos_ff;
      open_in    = open_ff;
      slots_in   = slots_ff;
      cmd_in     = cmd_ff;
      res_in     = res_ff;
      scan_in    = scan_ff;
      best_in    = best_ff;
      ptr_in     = ptr_ff;
      seg_end_in = seg_end_ff;
      more_in    = more_ff;
      mem_we     = 1'b0;
      mem_waddr  = tail_ff;
      mem_wdata  = cmd_ff.handle;
      mem_re     = 1'b0;
      mem_raddr  = head_ff;
      finish     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_pop) begin
               cmd_in   = cmd_data;
               res_in   = '0;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (cmd_ff.kind)
               KIND_ENQUEUE: begin
                  if (full && !broadcast) begin
                     res_in.status = STATUS_REFUSED;
                     finish        = 1'b1;
                  end else begin
                     mem_we        = 1'b1;
                     tail_in       = ring_next(tail_ff);
                     res_in.status = STATUS_OK;
                     if (full) begin
                        // evict the oldest handle
                        mem_re   = 1'b1;
                        head_in  = ring_next(head_ff);
                        pos_in   = pos_adv;
                        state_in = ST_REL;
                     end else begin
                        finish = 1'b1;
                     end
                  end
               end
               KIND_DEQUEUE: begin
                  if (head_ff == tail_ff) begin
                     res_in.status = STATUS_EMPTY;
                     finish        = 1'b1;
                  end else begin
                     mem_re        = 1'b1;
                     head_in       = ring_next(head_ff);
                     pos_in        = pos_adv;
                     res_in.status = STATUS_OK;
                     state_in      = ST_TAKE;
                  end
               end
               KIND_READ: begin
                  priority if (!open_ff[ridx]) begin
                     res_in.status = STATUS_REFUSED;
                     finish        = 1'b1;
                  end else if (pos_ff[ridx] == tail_ff) begin
                     res_in.status = STATUS_EMPTY;
                     finish        = 1'b1;
                  end else begin
                     mem_re        = 1'b1;
                     mem_raddr     = pos_ff[ridx];
                     pos_in[ridx]  = ring_next(pos_ff[ridx]);
                     scan_in       = '0;
                     best_in       = DW'(RING);
                     res_in.status = STATUS_OK;
                     state_in      = ST_SCAN;
                  end
               end
               KIND_OPEN: begin
                  if (free_hit) begin
                     open_in[free_idx] = 1'b1;
                     pos_in[free_idx]  = head_ff;
                     res_in.reader_out = free_num;
                     res_in.status     = STATUS_OK;
                  end else begin
                     res_in.status = STATUS_REFUSED;
                  end
                  finish = 1'b1;
               end
               KIND_CLOSE: begin
                  open_in[ridx] = 1'b0;
                  res_in.status = STATUS_OK;
                  finish        = 1'b1;
               end
               KIND_FIND: begin
                  // wrapped range: low segment first, then head to ring end
                  priority if (head_ff == tail_ff) begin
                     res_in.status = STATUS_EMPTY;
                     finish        = 1'b1;
                  end else if (head_ff < tail_ff) begin
                     ptr_in     = head_ff;
                     seg_end_in = {1'b0, tail_ff};
                     more_in    = 1'b0;
                     state_in   = ST_FRD;
                  end else if (tail_ff == '0) begin
                     ptr_in     = head_ff;
                     seg_end_in = DW'(RING);
                     more_in    = 1'b0;
                     state_in   = ST_FRD;
                  end else begin
                     ptr_in     = '0;
                     seg_end_in = {1'b0, tail_ff};
                     more_in    = 1'b1;
                     state_in   = ST_FRD;
                  end
               end
               default: begin
                  res_in.status = STATUS_REFUSED;
                  finish        = 1'b1;
               end
            endcase
         end
         ST_TAKE: begin
            res_in.handle_out = rd_data_ff;
            finish            = 1'b1;
         end
         ST_SCAN: begin
            // one reader per cycle, keep the smallest distance from head
            if (scan_ff == '0) begin
               res_in.handle_out = rd_data_ff;
            end
            if (open_ff[scan_ff] && (d_scan < best_ff)) begin
               best_in = d_scan;
            end
            if (int'(scan_ff) == int'(eff_n) - 1) begin
               state_in = ST_HEADMV;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_HEADMV: begin
            if ((best_ff != '0) && (best_ff < DW'(RING))) begin
               mem_re   = 1'b1;
               head_in  = ring_add(head_ff, best_ff[PW-1:0]);
               state_in = ST_REL;
            end else begin
               finish = 1'b1;
            end
         end
         ST_REL: begin
            res_in.released_handle = rd_data_ff;
            finish                 = 1'b1;
         end
         ST_FRD: begin
            mem_re    = 1'b1;
            mem_raddr = ptr_ff;
            state_in  = ST_FCMP;
         end
         ST_FCMP: begin
            priority if (rd_data_ff == cmd_ff.handle) begin
               mem_we        = cmd_ff.discard;
               mem_waddr     = ptr_ff;
               mem_wdata     = '0;
               res_in.found  = 1'b1;
               res_in.status = STATUS_OK;
               finish        = 1'b1;
            end else if (ptr_inc == seg_end_ff) begin
               if (more_ff) begin
                  ptr_in     = head_ff;
                  seg_end_in = DW'(RING);
                  more_in    = 1'b0;
                  state_in   = ST_FRD;
               end else begin
                  res_in.status = STATUS_EMPTY;
                  finish        = 1'b1;
               end
            end else begin
               ptr_in   = ptr_inc[PW-1:0];
               state_in = ST_FRD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (finish) begin
         state_in = ST_IDLE;
      end

      // mode register write closes every reader
      if (csr_write) begin
         slots_in = csr_data;
         open_in  = '0;
      end
   end

   // response register
   always_comb begin
      occ_wide         = {{OCCUPANCY_W{1'b0}}, ring_dist(head_in, tail_in)};
      rsp_in           = res_in;
      rsp_in.occupancy = occ_wide[OCCUPANCY_W-1:0];
      rsp_valid_in     = finish || (rsp_valid_ff && !rsp_ready);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         open_ff      <= '0;
         slots_ff     <= SLOTS_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         open_ff      <= open_in;
         slots_ff     <= slots_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      cmd_ff     <= cmd_in;
      res_ff     <= res_in;
      scan_ff    <= scan_in;
      best_ff    <= best_in;
      ptr_ff     <= ptr_in;
      seg_end_ff <= seg_end_in;
      more_ff    <= more_in;
      if (finish) begin
         rsp_ff <= rsp_in;
      end
   end

   // slot memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= slot_mem[mem_raddr];
      end
   end

`ifndef SYNTHESIS
   // a result is only produced into a free response register
   assert property (@(posedge clock) disable iff (reset)
      finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register overwritten");

   // fifo mode never has an open reader
   assert property (@(posedge clock) disable iff (reset)
      !broadcast |-> (open_ff == '0))
      else $error("reader open in fifo mode");

   // the head only moves while a command is being executed
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |=> $stable(head_ff))
      else $error("head moved while idle");

   // a new response always comes with the engine back in idle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (state_ff == ST_IDLE))
      else $error("response raised outside command end");
`endif

endmodule

>>> rtl/multi_reader_frame_queue.sv
// The engine runs one command at a time. A reader read scans the reader slots
// and may then move the head; a find reads and compares one ring slot at a time.
// Reset: head and tail zero, all readers closed, one reader slot; the slot
// memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// multi_reader_frame_queue: ring queue of frame handles with reader slots
// Front end classifies requests, a command queue decouples it from the
// execution engine that owns the ring, reader positions and mode register.
// ----------------------------------------------------------------------------
module multi_reader_frame_queue #(
   parameter int CAPACITY    = 15
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  mrfq_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output mrfq_pkg::rsp_type            rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [mrfq_pkg::SLOTS_W-1:0] csr_data
);
   import mrfq_pkg::*;

   logic            push_valid, push_ready;
   cmd_type         push_data;
   logic            cmd_valid, cmd_pop;
   cmd_type         cmd_data;
   back_status_type back_status;
   logic            csr_write;

   // mode register transfer only while nothing is in flight
   assign csr_ready = back_status.idle && !cmd_valid;
   assign csr_write = csr_valid && csr_ready;

   mrfq_front u_front (
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .back_status (back_status),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   mrfq_cmd_fifo u_cmd_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (cmd_valid),
      .pop_ready  (cmd_pop),
      .pop_data   (cmd_data)
   );

   mrfq_back #(
      .CAPACITY    (CAPACITY)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd_pop     (cmd_pop),
      .cmd_data    (cmd_data),
      .csr_write   (csr_write),
      .csr_data    (csr_data),
      .back_status (back_status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the multi-reader frame queue
// Sends request and register transfers under several idle profiles, predicts
// each response with a behavioral copy of the ring and its reader slots, and
// compares every response field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
   import mrfq_pkg::*;

   localparam int RING_SLOTS   = 16;
   localparam int PHASE_ITEMS  = 270;
   localparam int DRAIN_CYCLES = 40;

   // operation codes the block does not define
   localparam logic [OPERATION_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OPERATION_W-1:0] OP_SPARE_HI = 3'd7;

   typedef bit [3:0] ring_index_type;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   req_type            req_data  = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   rsp_type            rsp_data;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [SLOTS_W-1:0] csr_data  = '0;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int error_count    = 0;

   // responses still owed by the block, oldest first
   rsp_type pending_rsp[$];

   // predicted queue state
   bit [HANDLE_W-1:0]  ring_handles [RING_SLOTS];
   ring_index_type     ring_head = '0;
   ring_index_type     ring_tail = '0;
   ring_index_type     reader_at [MAX_READERS];
   bit                 reader_live [MAX_READERS];
   bit [SLOTS_W-1:0]   reader_slots_reg = 3'd1;

   multi_reader_frame_queue #(
      .CAPACITY    (15)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // clock
   always #5 clock = ~clock;

   // run limit
   initial begin
      #5_000_000;
      $display("** multi_reader_frame_queue: FAILED **");
      $finish;
   end

   // response channel back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // ------------------------------------------------------------------------
   // queue prediction
   // ------------------------------------------------------------------------
   function automatic ring_index_type next_slot(input ring_index_type p);
      return p + 1'b1;
   endfunction

   // slot count after clamping 0 up and large values down
   function automatic int active_readers();
      if (reader_slots_reg == 0) return 1;
      if (reader_slots_reg > MAX_READERS) return MAX_READERS;
      return int'(reader_slots_reg);
   endfunction

   // head steps by one and drags along any reader sitting on it
   function automatic void advance_head();
      for (int i = 0; i < active_readers(); i++) begin
         if (reader_live[i] && reader_at[i] == ring_head) reader_at[i] = next_slot(ring_head);
      end
      ring_head = next_slot(ring_head);
   endfunction

   function automatic bit find_in_ring(input bit [HANDLE_W-1:0] value, input int first,
                                       input int last, input bit clear);
      for (int p = first; p < last; p++) begin
         if (ring_handles[p] == value) begin
            if (clear) ring_handles[p] = '0;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic rsp_type predict_queue_step(input req_type item);
      rsp_type        res;
      int             readers;
      bit             broadcast;
      int             slot;
      int             nearest;
      ring_index_type gap;
      ring_index_type lead;
      bit             hit;
      res        = '0;
      res.status = STATUS_REFUSED;
      readers    = active_readers();
      broadcast  = readers > 1;
      slot       = int'(item.reader_id) - 1;
      case (item.operation)
         OP_ENQUEUE: begin
            if (item.handle != '0 && (next_slot(ring_tail) != ring_head || broadcast)) begin
               // full in broadcast mode: oldest handle is evicted
               if (next_slot(ring_tail) == ring_head) begin
                  res.released_handle = ring_handles[ring_head];
                  advance_head();
               end
               ring_handles[ring_tail] = item.handle;
               ring_tail  = next_slot(ring_tail);
               res.status = STATUS_OK;
            end
         end
         OP_DEQUEUE: begin
            if (ring_head == ring_tail) begin
               res.status = STATUS_EMPTY;
            end else begin
               res.handle_out = ring_handles[ring_head];
               advance_head();
               res.status = STATUS_OK;
            end
         end
         OP_READ: begin
            if (broadcast && slot >= 0 && slot < readers && reader_live[slot]) begin
               if (reader_at[slot] == ring_tail) begin
                  res.status = STATUS_EMPTY;
               end else begin
                  res.handle_out  = ring_handles[reader_at[slot]];
                  reader_at[slot] = next_slot(reader_at[slot]);
                  // head follows the reader furthest behind, measured from the head
                  nearest = RING_SLOTS;
                  lead    = ring_head;
                  for (int i = 0; i < readers; i++) begin
                     gap = reader_at[i] - ring_head;
                     if (reader_live[i] && int'(gap) < nearest) begin
                        nearest = int'(gap);
                        lead    = reader_at[i];
                     end
                  end
                  if (nearest < RING_SLOTS && lead != ring_head) begin
                     res.released_handle = ring_handles[ring_head];
                     ring_head = lead;
                  end
                  res.status = STATUS_OK;
               end
            end
         end
         OP_OPEN: begin
            if (broadcast) begin
               for (int i = 0; i < readers; i++) begin
                  if (!reader_live[i] && res.reader_out == 0) begin
                     reader_live[i] = 1'b1;
                     reader_at[i]   = ring_head;
                     res.reader_out = READER_W'(i + 1);
                     res.status     = STATUS_OK;
                  end
               end
            end
         end
         OP_CLOSE: begin
            if (broadcast && slot >= 0 && slot < readers) begin
               reader_live[slot] = 1'b0;
               res.status        = STATUS_OK;
            end
         end
         OP_FIND: begin
            if (item.handle != '0) begin
               // a wrapped range is searched low part first
               if (ring_head <= ring_tail) begin
                  hit = find_in_ring(item.handle, int'(ring_head), int'(ring_tail),
                                     item.discard);
               end else begin
                  hit = find_in_ring(item.handle, 0, int'(ring_tail), item.discard);
                  if (!hit) begin
                     hit = find_in_ring(item.handle, int'(ring_head), RING_SLOTS,
                                        item.discard);
                  end
               end
               res.found  = hit;
               res.status = hit ? STATUS_OK : STATUS_EMPTY;
            end
         end
         default: begin
         end
      endcase
      res.occupancy = ring_tail - ring_head;
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // response checking
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("response transfer with no request outstanding");
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.handle_out !== want.handle_out) begin
               $error("handle_out: expected %h, actual %h", want.handle_out,
                      rsp_data.handle_out);
               error_count++;
            end
            if (rsp_data.reader_out !== want.reader_out) begin
               $error("reader_out: expected %0d, actual %0d", want.reader_out,
                      rsp_data.reader_out);
               error_count++;
            end
            if (rsp_data.released_handle !== want.released_handle) begin
               $error("released_handle: expected %h, actual %h", want.released_handle,
                      rsp_data.released_handle);
               error_count++;
            end
            if (rsp_data.found !== want.found) begin
               $error("found: expected %0d, actual %0d", want.found, rsp_data.found);
               error_count++;
            end
            if (rsp_data.occupancy !== want.occupancy) begin
               $error("occupancy: expected %0d, actual %0d", want.occupancy,
                      rsp_data.occupancy);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // transfer helpers
   // ------------------------------------------------------------------------
   function automatic req_type make_request(input logic [OPERATION_W-1:0] op,
                                            input logic [HANDLE_W-1:0] value,
                                            input logic [READER_W-1:0] rid,
                                            input logic drop);
      req_type item;
      item.operation = op;
      item.handle    = value;
      item.reader_id = rid;
      item.discard   = drop;
      return item;
   endfunction

   // one request transfer; valid stays up so a following item goes back to back
   task automatic send_request(input req_type item);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_rsp.push_back(predict_queue_step(item));
   endtask

   // sender goes quiet until every owed response has arrived
   task automatic wait_all_responses();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_reader_slots(input logic [SLOTS_W-1:0] value);
      wait_all_responses();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      // a register write closes every reader
      reader_slots_reg = value;
      for (int i = 0; i < MAX_READERS; i++) begin
         reader_live[i] = 1'b0;
         reader_at[i]   = '0;
      end
   endtask

   task automatic set_idle_profile(input int profile);
      case (profile)
         1:       begin send_idle_pct = 47; recv_stall_pct = 0;  end
         2:       begin send_idle_pct = 0;  recv_stall_pct = 47; end
         3:       begin send_idle_pct = 35; recv_stall_pct = 35; end
         default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   // single-reader mode straight after reset
   task automatic test_fifo_cases();
      set_idle_profile(0);
      send_request(make_request(OP_DEQUEUE, '0, '0, 1'b0));
      send_request(make_request(OP_ENQUEUE, '0, '0, 1'b0));
      send_request(make_request(OP_ENQUEUE, 16'hFFFF, 3'd7, 1'b1));
      send_request(make_request(OP_ENQUEUE, 16'h0001, '0, 1'b0));
      send_request(make_request(OP_FIND, 16'h0001, '0, 1'b1));
      send_request(make_request(OP_FIND, 16'h0001, '0, 1'b0));
      send_request(make_request(OP_FIND, '0, '0, 1'b0));
      send_request(make_request(OP_READ, '0, 3'd1, 1'b0));
      send_request(make_request(OP_OPEN, '0, '0, 1'b0));
      send_request(make_request(OP_CLOSE, '0, 3'd1, 1'b0));
      send_request(make_request(OP_SPARE_LO, 16'h1234, 3'd1, 1'b0));
      send_request(make_request(OP_SPARE_HI, 16'hFFFF, 3'd7, 1'b1));
      // slot nulled by the find comes back as handle zero
      send_request(make_request(OP_DEQUEUE, '0, '0, 1'b0));
      send_request(make_request(OP_DEQUEUE, '0, '0, 1'b0));
   endtask

   // two reader slots: grants, bad readers, head movement, broadcast dequeue
   task automatic test_broadcast_cases();
      write_reader_slots(3'd2);
      set_idle_profile(3);
      send_request(make_request(OP_OPEN, '0, '0, 1'b0));
      send_request(make_request(OP_OPEN, '0, '0, 1'b0));
      send_request(make_request(OP_OPEN, '0, '0, 1'b0));
      send_request(make_request(OP_READ, '0, 3'd0, 1'b0));
      send_request(make_request(OP_READ, '0, 3'd3, 1'b0));
      send_request(make_request(OP_READ, '0, 3'd1, 1'b0));
      send_request(make_request(OP_ENQUEUE, 16'h00AA, '0, 1'b0));
      send_request(make_request(OP_ENQUEUE, 16'h5500, '0, 1'b0));
      send_request(make_request(OP_READ, '0, 3'd1, 1'b0));
      send_request(make_request(OP_READ, '0, 3'd2, 1'b0));
      send_request(make_request(OP_CLOSE, '0, 3'd2, 1'b0));
      send_request(make_request(OP_READ, '0, 3'd2, 1'b0));
      send_request(make_request(OP_CLOSE, '0, 3'd2, 1'b0));
      send_request(make_request(OP_DEQUEUE, '0, '0, 1'b0));
   endtask

   // random traffic under one register setting; blocks alternate filling and draining
   task automatic test_random_traffic(input logic [SLOTS_W-1:0] slots_value,
                                      input int profile);
      int unsigned            pick;
      int unsigned            hsel;
      logic [HANDLE_W-1:0]    value;
      logic [OPERATION_W-1:0] op;
      logic [READER_W-1:0]    rid;
      bit                     fill_block;
      write_reader_slots(slots_value);
      set_idle_profile(profile);
      // bring every reader slot online first
      if (active_readers() > 1) begin
         for (int i = 0; i < active_readers(); i++) begin
            send_request(make_request(OP_OPEN, '0, '0, 1'b0));
         end
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if (n == PHASE_ITEMS / 2) wait_all_responses();
         fill_block = ((n / 40) % 2) == 0;
         pick = $urandom_range(0, 99);
         if (pick < (fill_block ? 55 : 20)) op = OP_ENQUEUE;
         else if (pick < (fill_block ? 65 : 40)) op = OP_DEQUEUE;
         else if (pick < (fill_block ? 80 : 70)) op = OP_READ;
         else if (pick < (fill_block ? 84 : 76)) op = OP_OPEN;
         else if (pick < (fill_block ? 87 : 80)) op = OP_CLOSE;
         else if (pick < 97) op = OP_FIND;
         else op = pick[0] ? OP_SPARE_HI : OP_SPARE_LO;
         // small handle pool so finds hit, some full-range and null handles
         hsel = $urandom_range(0, 19);
         if (hsel == 0) value = '0;
         else if (hsel < 4) value = HANDLE_W'($urandom_range(0, 16'hFFFF));
         else value = HANDLE_W'($urandom_range(1, 24));
         if ($urandom_range(0, 9) < 8) rid = READER_W'($urandom_range(1, active_readers()));
         else rid = READER_W'($urandom_range(0, 7));
         send_request(make_request(op, value, rid, 1'($urandom_range(0, 1))));
      end
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fifo_cases();
      test_broadcast_cases();
      test_random_traffic(3'd4, 0);
      test_random_traffic(3'd1, 1);
      test_random_traffic(3'd2, 2);
      test_random_traffic(3'd0, 3);
      test_random_traffic(3'd7, 3);
      test_random_traffic(3'd3, 0);
      wait_all_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("** multi_reader_frame_queue: PASSED **");
      end else begin
         $display("** multi_reader_frame_queue: FAILED **");
      end
      $finish;
   end

endmodule

>>> multi_reader_frame_queue.f
rtl/mrfq_pkg.sv
rtl/mrfq_front.sv
rtl/mrfq_cmd_fifo.sv
rtl/mrfq_back.sv
rtl/multi_reader_frame_queue.sv
dv/tb_top.sv
